FILE: rtl/ftp_session_state_monitor_macros.svh
// Assertion macros shared by the session monitor RTL.
// No dependencies.
`ifndef FTP_SESSION_STATE_MONITOR_MACROS_SVH
`define FTP_SESSION_STATE_MONITOR_MACROS_SVH
`define FSM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define FSM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

FILE: rtl/ftpmon_pkg.sv
// Types, constants and verb lookup for the FTP session monitor.
// No dependencies.
`timescale 1ns / 1ps
package ftpmon_pkg;
	localparam int MAX_COMMAND_LENGTH = 512;
	localparam int TOKEN_LIMIT = 15;

	localparam logic [1:0] ACT_CMD_BYTE = 2'd0;
	localparam logic [1:0] ACT_RPL_BYTE = 2'd1;
	localparam logic [1:0] ACT_CMD_EMPTY = 2'd2;
	localparam logic [1:0] ACT_RPL_EMPTY = 2'd3;

	localparam logic [5:0] V_NONE = 6'd0;
	localparam logic [5:0] V_USER = 6'd1;
	localparam logic [5:0] V_PASS = 6'd2;
	localparam logic [5:0] V_ACCT = 6'd3;
	localparam logic [5:0] V_CWD = 6'd4;
	localparam logic [5:0] V_CDUP = 6'd5;
	localparam logic [5:0] V_SMNT = 6'd6;
	localparam logic [5:0] V_QUIT = 6'd7;
	localparam logic [5:0] V_REIN = 6'd8;
	localparam logic [5:0] V_PORT = 6'd9;
	localparam logic [5:0] V_PASV = 6'd10;
	localparam logic [5:0] V_TYPE = 6'd11;
	localparam logic [5:0] V_STRU = 6'd12;
	localparam logic [5:0] V_MODE = 6'd13;
	localparam logic [5:0] V_RETR = 6'd14;
	localparam logic [5:0] V_STOR = 6'd15;
	localparam logic [5:0] V_STOU = 6'd16;
	localparam logic [5:0] V_APPE = 6'd17;
	localparam logic [5:0] V_ALLO = 6'd18;
	localparam logic [5:0] V_REST = 6'd19;
	localparam logic [5:0] V_RNFR = 6'd20;
	localparam logic [5:0] V_RNTO = 6'd21;
	localparam logic [5:0] V_ABOR = 6'd22;
	localparam logic [5:0] V_DELE = 6'd23;
	localparam logic [5:0] V_RMD = 6'd24;
	localparam logic [5:0] V_MKD = 6'd25;
	localparam logic [5:0] V_PWD = 6'd26;
	localparam logic [5:0] V_LIST = 6'd27;
	localparam logic [5:0] V_NLST = 6'd28;
	localparam logic [5:0] V_SITE = 6'd29;
	localparam logic [5:0] V_SYST = 6'd30;
	localparam logic [5:0] V_STAT = 6'd31;
	localparam logic [5:0] V_HELP = 6'd32;
	localparam logic [5:0] V_NOOP = 6'd33;
	localparam logic [5:0] V_FEAT = 6'd34;
	localparam logic [5:0] V_OPTS = 6'd35;
	localparam logic [5:0] V_AUTH = 6'd36;
	localparam logic [5:0] V_PBSZ = 6'd37;
	localparam logic [5:0] V_PROT = 6'd38;
	localparam logic [5:0] V_EPRT = 6'd39;
	localparam logic [5:0] V_EPSV = 6'd40;
	localparam logic [5:0] V_SIZE = 6'd41;
	localparam logic [5:0] V_MLSD = 6'd42;
	localparam logic [5:0] V_MLST = 6'd43;

	localparam int F_LOGGED_IN = 0;
	localparam int F_DATA_OPEN = 1;
	localparam int F_XFER_PROG = 2;
	localparam int F_CLOSED = 3;
	localparam int F_USER_SENT = 4;
	localparam int F_PASS_SENT = 5;
	localparam int F_LOGIN_OK = 6;
	localparam int F_LOGIN_FAIL = 7;
	localparam int F_PORT_SENT = 8;
	localparam int F_PASV_SENT = 9;
	localparam int F_PASV_RESP = 10;
	localparam int F_PORT_ACC = 11;
	localparam int F_RETR = 12;
	localparam int F_STOR = 13;
	localparam int F_XFER_START = 14;
	localparam int F_XFER_DONE = 15;
	localparam int F_XFER_ABORT = 16;
	localparam int F_RNFR_SENT = 17;
	localparam int F_RNFR_ACC = 18;
	localparam int F_RNTO = 19;
	localparam int F_SESS_INIT = 20;
	localparam int F_QUIT = 21;
	localparam int F_REIN = 22;

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] byte_value;
		logic last_byte;
	} in_item_t;

	typedef struct packed {
		logic is_reply;
		logic [5:0] command_code;
		logic [2:0] reply_class;
		logic [9:0] reply_code;
		logic [31:0] sequence_count;
		logic signed [31:0] restart_position;
		logic malformed;
		logic timed_out;
		logic [22:0] session_bits;
		logic [2:0] auth_phase;
		logic [1:0] data_phase;
	} out_item_t;

	function automatic logic [5:0] verb_lookup(input logic [31:0] tok, input logic [3:0] len);
		logic [5:0] v;
		v = V_NONE;
		if (len == 4'd3) begin
			unique case (tok[23:0])
				"DWC": v = V_CWD;
				"DMR": v = V_RMD;
				"DKM": v = V_MKD;
				"DWP": v = V_PWD;
				default: v = V_NONE;
			endcase
		end else if (len == 4'd4) begin
			unique case (tok)
				"RESU": v = V_USER; "SSAP": v = V_PASS; "TCCA": v = V_ACCT;
				"PUDC": v = V_CDUP; "TNMS": v = V_SMNT; "TIUQ": v = V_QUIT;
				"NIER": v = V_REIN; "TROP": v = V_PORT; "VSAP": v = V_PASV;
				"EPYT": v = V_TYPE; "URTS": v = V_STRU; "EDOM": v = V_MODE;
				"RTER": v = V_RETR; "ROTS": v = V_STOR; "UOTS": v = V_STOU;
				"EPPA": v = V_APPE; "OLLA": v = V_ALLO; "TSER": v = V_REST;
				"RFNR": v = V_RNFR; "OTNR": v = V_RNTO; "ROBA": v = V_ABOR;
				"ELED": v = V_DELE; "TSIL": v = V_LIST; "TSLN": v = V_NLST;
				"ETIS": v = V_SITE; "TSYS": v = V_SYST; "TATS": v = V_STAT;
				"PLEH": v = V_HELP; "POON": v = V_NOOP; "TAEF": v = V_FEAT;
				"STPO": v = V_OPTS; "HTUA": v = V_AUTH; "ZSBP": v = V_PBSZ;
				"TORP": v = V_PROT; "TRPE": v = V_EPRT; "VSPE": v = V_EPSV;
				"EZIS": v = V_SIZE; "DSLM": v = V_MLSD; "TSLM": v = V_MLST;
				default: v = V_NONE;
			endcase
		end
		return v;
	endfunction
endpackage

FILE: rtl/ftp_session_state_monitor.sv
// FTP control-session monitor: byte parser, session flags and verdict register.
// Depends on ftpmon_pkg and ftp_session_state_monitor_macros.svh.
// A verdict is registered and appears in the cycle after the transfer of a message's last byte.
// Throughput: one byte per cycle; the input is held only while a verdict waits.
// Reset clears all session and parse state and the output valid.
`timescale 1ns / 1ps
`include "ftp_session_state_monitor_macros.svh"
module ftp_session_state_monitor (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  ftpmon_pkg::in_item_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output ftpmon_pkg::out_item_t out_data
);
	typedef struct packed {
		logic [22:0] flags;
		logic [5:0] cmd;
		logic [31:0] cnt;
		logic [31:0] rst;
		logic [9:0] nb;
		logic [9:0] nl;
		logic [31:0] tok;
		logic [31:0] acc;
		logic [3:0] tl;
		logic [8:0] ph;
		logic emit;
		ftpmon_pkg::out_item_t o;
	} next_t;

	logic [22:0] flags_q;
	logic [5:0] cmd_q;
	logic [31:0] count_q;
	logic [31:0] rest_q;
	logic [9:0] bytes_q;
	logic [31:0] tok_q;
	logic [3:0] toklen_q;
	logic [31:0] acc_q;
	logic [9:0] line_q;
	logic dir_q, tokdone_q, codefail_q, argstart_q, linefail_q;
	logic argneg_q, lastcr_q, argstop_q, bad_q;
	logic out_valid_q;
	ftpmon_pkg::out_item_t out_q;
	next_t nx;

	logic take;
	assign in_ready = !out_valid_q || out_ready;
	assign take = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	always_comb begin
		logic [22:0] f;
		logic [5:0] cmd;
		logic [31:0] cnt, rst;
		logic [9:0] nb, nl;
		logic [31:0] tok, acc;
		logic [3:0] tl;
		logic dir, tokdone, codefail, argstart, linefail, argneg, lastcr, argstop, bad;
		logic [7:0] b;
		logic last, emitv, rply, d, ws, first, mal, to;
		logic [9:0] code, eff;
		logic [2:0] cls;
		logic [35:0] prod;
		logic [7:0] c;
		logic [5:0] v;
		// defaults
		f = flags_q; cmd = cmd_q; cnt = count_q; rst = rest_q;
		nb = bytes_q; nl = line_q; tok = tok_q; acc = acc_q; tl = toklen_q;
		dir = dir_q; tokdone = tokdone_q; codefail = codefail_q; argstart = argstart_q;
		linefail = linefail_q; argneg = argneg_q; lastcr = lastcr_q; argstop = argstop_q;
		bad = bad_q;
		b = in_data.byte_value; last = in_data.last_byte;
		emitv = 1'b0; rply = 1'b0; code = '0; cls = '0; mal = 1'b0; to = 1'b0;
		d = (b >= 8'h30) && (b <= 8'h39);
		ws = (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
		prod = '0; c = '0; v = ftpmon_pkg::V_NONE; eff = '0; first = 1'b0;
		if (in_data.action == ftpmon_pkg::ACT_CMD_EMPTY
				|| in_data.action == ftpmon_pkg::ACT_RPL_EMPTY) begin
			nb = '0; nl = '0; tok = '0; acc = '0; tl = '0;
			dir = 1'b0; tokdone = 1'b0; codefail = 1'b0; argstart = 1'b0;
			linefail = 1'b0; argneg = 1'b0; lastcr = 1'b0; argstop = 1'b0; bad = 1'b0;
			emitv = 1'b1;
			rply = (in_data.action == ftpmon_pkg::ACT_RPL_EMPTY);
		end else begin
			if (bytes_q == 10'd0 && in_data.action == ftpmon_pkg::ACT_RPL_BYTE) dir = 1'b1;
			rply = dir;
			if (!rply) begin
				if (bytes_q >= 10'(ftpmon_pkg::MAX_COMMAND_LENGTH)) bad = 1'b1;
				if (b == 8'h00 && !last) bad = 1'b1;
				if (!tokdone && !(b == 8'h20 || b == 8'h0D || b == 8'h0A || b == 8'h00)) begin
					if (tl < 4'(ftpmon_pkg::TOKEN_LIMIT)) begin
						c = (b >= 8'h61 && b <= 8'h7A) ? b - 8'h20 : b;
						case (tl)
							4'd0: tok[7:0] = c;
							4'd1: tok[15:8] = c;
							4'd2: tok[23:16] = c;
							4'd3: tok[31:24] = c;
							default: tok = tok;
						endcase
						tl = tl + 4'd1;
					end else begin
						tokdone = 1'b1;
					end
				end else begin
					tokdone = 1'b1;
					if (!argstop && !(!argstart && ws)) begin
						if (!argstart && (b == 8'h2B || b == 8'h2D)) begin
							argstart = 1'b1;
							if (b == 8'h2D) argneg = 1'b1;
						end else if (d) begin
							prod = 36'(acc) * 36'd10 + 36'(b - 8'h30);
							acc = (prod > 36'h80000000) ? 32'h80000000 : prod[31:0];
							argstart = 1'b1;
						end else begin
							argstop = 1'b1;
						end
					end
				end
			end else begin
				if (bytes_q < 10'd3) begin
					if (d) acc = acc * 32'd10 + 32'(b - 8'h30);
					else codefail = 1'b1;
				end
				if (b == 8'h0A) begin
					eff = (lastcr && line_q != 10'd0) ? line_q - 10'd1 : line_q;
					if (eff < 10'd4 || linefail) bad = 1'b1;
					nl = '0; linefail = 1'b0; lastcr = 1'b0;
				end else begin
					if (line_q < 10'd3 && !d) linefail = 1'b1;
					if (line_q != 10'd1023) nl = line_q + 10'd1;
					lastcr = (b == 8'h0D);
				end
			end
			if (bytes_q != 10'd1023) nb = bytes_q + 10'd1;
			emitv = last;
		end
		if (emitv && !rply) begin
			v = ftpmon_pkg::verb_lookup(tok, tl);
			cmd = v;
			unique case (v)
				ftpmon_pkg::V_USER: f[ftpmon_pkg::F_USER_SENT] = 1'b1;
				ftpmon_pkg::V_PASS: f[ftpmon_pkg::F_PASS_SENT] = 1'b1;
				ftpmon_pkg::V_PORT: begin
					f[ftpmon_pkg::F_PORT_SENT] = 1'b1; f[ftpmon_pkg::F_PASV_SENT] = 1'b0;
				end
				ftpmon_pkg::V_PASV: begin
					f[ftpmon_pkg::F_PASV_SENT] = 1'b1; f[ftpmon_pkg::F_PORT_SENT] = 1'b0;
				end
				ftpmon_pkg::V_RETR: f[ftpmon_pkg::F_RETR] = 1'b1;
				ftpmon_pkg::V_STOR: f[ftpmon_pkg::F_STOR] = 1'b1;
				ftpmon_pkg::V_RNFR: f[ftpmon_pkg::F_RNFR_SENT] = 1'b1;
				ftpmon_pkg::V_RNTO: f[ftpmon_pkg::F_RNTO] = 1'b1;
				ftpmon_pkg::V_ABOR: begin
					f[ftpmon_pkg::F_XFER_ABORT] = 1'b1; f[ftpmon_pkg::F_XFER_PROG] = 1'b0;
				end
				ftpmon_pkg::V_QUIT: f[ftpmon_pkg::F_QUIT] = 1'b1;
				ftpmon_pkg::V_REIN: f[ftpmon_pkg::F_REIN] = 1'b1;
				ftpmon_pkg::V_REST: begin
					if (argneg) rst = acc[31] ? 32'h80000000 : 32'd0 - acc;
					else rst = acc[31] ? 32'h7FFFFFFF : acc;
				end
				default: f = f;
			endcase
			cnt = count_q + 32'd1;
			mal = (nb == 10'd0) || bad || (tl == 4'd0);
		end else if (emitv) begin
			if (nl != 10'd0) begin
				eff = (lastcr && nl != 10'd0) ? nl - 10'd1 : nl;
				if (eff < 10'd4 || linefail) bad = 1'b1;
			end
			code = (nb >= 10'd3 && !codefail) ? acc[9:0] : 10'd0;
			cls = (code >= 10'd100 && code < 10'd600)
				? ((code >= 10'd500) ? 3'd5 : (code >= 10'd400) ? 3'd4
				: (code >= 10'd300) ? 3'd3 : (code >= 10'd200) ? 3'd2 : 3'd1) : 3'd0;
			mal = (nb == 10'd0) || bad;
			to = (code == 10'd0);
			first = (count_q == 32'd0);
			if (cmd_q == ftpmon_pkg::V_NONE) begin
				if (code == 10'd220 && !first && f[ftpmon_pkg::F_REIN]) cmd = ftpmon_pkg::V_REIN;
				else if (code == 10'd331 && f[ftpmon_pkg::F_USER_SENT]) cmd = ftpmon_pkg::V_USER;
				else if (code == 10'd230 && !first && f[ftpmon_pkg::F_PASS_SENT])
					cmd = ftpmon_pkg::V_PASS;
				else if (code == 10'd227 && f[ftpmon_pkg::F_PASV_SENT]) cmd = ftpmon_pkg::V_PASV;
				else if (code == 10'd350 && f[ftpmon_pkg::F_RNFR_SENT]) cmd = ftpmon_pkg::V_RNFR;
				else if (code == 10'd221 && f[ftpmon_pkg::F_QUIT]) cmd = ftpmon_pkg::V_QUIT;
				else if (code == 10'd257) cmd = ftpmon_pkg::V_PWD;
				else if (code == 10'd215) cmd = ftpmon_pkg::V_SYST;
				else if (code == 10'd211) cmd = ftpmon_pkg::V_FEAT;
			end
			cnt = count_q + 32'd1;
			if (code == 10'd220 && first) f[ftpmon_pkg::F_SESS_INIT] = 1'b1;
			else if (code == 10'd230) begin
				f[ftpmon_pkg::F_LOGGED_IN] = 1'b1; f[ftpmon_pkg::F_LOGIN_OK] = 1'b1;
			end else if (code == 10'd530) begin
				f[ftpmon_pkg::F_LOGIN_FAIL] = 1'b1; f[ftpmon_pkg::F_LOGGED_IN] = 1'b0;
			end else if (code == 10'd200 && cmd == ftpmon_pkg::V_PORT)
				f[ftpmon_pkg::F_PORT_ACC] = 1'b1;
			else if (code == 10'd227) f[ftpmon_pkg::F_PASV_RESP] = 1'b1;
			else if (code == 10'd150) begin
				f[ftpmon_pkg::F_XFER_START] = 1'b1; f[ftpmon_pkg::F_XFER_PROG] = 1'b1;
				f[ftpmon_pkg::F_DATA_OPEN] = 1'b1;
			end else if (code == 10'd226) begin
				f[ftpmon_pkg::F_XFER_DONE] = 1'b1; f[ftpmon_pkg::F_XFER_PROG] = 1'b0;
				f[ftpmon_pkg::F_DATA_OPEN] = 1'b0;
			end else if (code == 10'd350 && cmd == ftpmon_pkg::V_RNFR)
				f[ftpmon_pkg::F_RNFR_ACC] = 1'b1;
			else if (code == 10'd220 && cmd == ftpmon_pkg::V_REIN) begin
				f = '0; f[ftpmon_pkg::F_SESS_INIT] = 1'b1;
				cmd = ftpmon_pkg::V_NONE; cnt = 32'd1; rst = '0;
			end else if (code == 10'd221) f[ftpmon_pkg::F_CLOSED] = 1'b1;
		end
		if (emitv) begin
			nb = '0; nl = '0; tok = '0; acc = '0; tl = '0;
			dir = 1'b0; tokdone = 1'b0; codefail = 1'b0; argstart = 1'b0;
			linefail = 1'b0; argneg = 1'b0; lastcr = 1'b0; argstop = 1'b0; bad = 1'b0;
		end
		nx.flags = f; nx.cmd = cmd; nx.cnt = cnt; nx.rst = rst; nx.nb = nb; nx.nl = nl;
		nx.tok = tok; nx.acc = acc; nx.tl = tl;
		nx.ph = {dir, tokdone, codefail, argstart, linefail, argneg, lastcr, argstop, bad};
		nx.emit = emitv;
		nx.o.is_reply = rply;
		nx.o.command_code = cmd;
		nx.o.reply_class = cls;
		nx.o.reply_code = code;
		nx.o.sequence_count = cnt;
		nx.o.restart_position = rst;
		nx.o.malformed = mal;
		nx.o.timed_out = to;
		nx.o.session_bits = f;
		nx.o.auth_phase = f[ftpmon_pkg::F_LOGGED_IN] ? 3'd4 : f[ftpmon_pkg::F_LOGIN_FAIL] ? 3'd3
			: f[ftpmon_pkg::F_PASS_SENT] ? 3'd2 : f[ftpmon_pkg::F_USER_SENT] ? 3'd1 : 3'd0;
		nx.o.data_phase = f[ftpmon_pkg::F_DATA_OPEN] ? 2'd3 : f[ftpmon_pkg::F_PORT_SENT] ? 2'd2
			: f[ftpmon_pkg::F_PASV_SENT] ? 2'd1 : 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0; cmd_q <= '0; count_q <= '0; rest_q <= '0;
			bytes_q <= '0; tok_q <= '0; toklen_q <= '0; acc_q <= '0; line_q <= '0;
			{dir_q, tokdone_q, codefail_q, argstart_q, linefail_q,
				argneg_q, lastcr_q, argstop_q, bad_q} <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				flags_q <= nx.flags; cmd_q <= nx.cmd; count_q <= nx.cnt; rest_q <= nx.rst;
				bytes_q <= nx.nb; tok_q <= nx.tok; toklen_q <= nx.tl; acc_q <= nx.acc;
				line_q <= nx.nl;
				{dir_q, tokdone_q, codefail_q, argstart_q, linefail_q,
					argneg_q, lastcr_q, argstop_q, bad_q} <= nx.ph;
			end
			if (take) out_valid_q <= nx.emit;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && nx.emit) out_q <= nx.o;
	end

	`FSM_ASSERT_IMPL(a_stall_hold, clk, arst_n, out_valid_q && !out_ready, !in_ready)
	`FSM_ASSERT_NEXT(a_emit_valid, clk, arst_n, take && nx.emit, out_valid_q)
	`FSM_ASSERT_NEXT(a_msg_clear, clk, arst_n, take && nx.emit, bytes_q == 10'd0)
	`FSM_ASSERT_IMPL(a_cmd_range, clk, arst_n, out_valid_q, out_q.command_code <= ftpmon_pkg::V_MLST)
endmodule

FILE: dv/ftp_session_state_monitor_tb.sv
// Self-checking testbench for the FTP session state monitor.
// Drives directed and random control messages and predicts every verdict.
// Depends on ftpmon_pkg and the ftp_session_state_monitor RTL.
`timescale 1ns / 1ps
module ftp_session_state_monitor_tb;
	localparam int CYCLE_LIMIT = 400000;
	localparam int ITEM_TARGET = 600;
	localparam int QUIET_FROM = 500;

	localparam logic [7:0] P_DIR      = 8'h01;
	localparam logic [7:0] P_TOKDONE  = 8'h02;
	localparam logic [7:0] P_CODEFAIL = 8'h02;
	localparam logic [7:0] P_ARGSTART = 8'h04;
	localparam logic [7:0] P_LINEFAIL = 8'h04;
	localparam logic [7:0] P_ARGNEG   = 8'h08;
	localparam logic [7:0] P_LASTCR   = 8'h08;
	localparam logic [7:0] P_ARGSTOP  = 8'h10;
	localparam logic [7:0] P_BAD      = 8'h20;

	class session_scoreboard;
		string verbs[43] = '{"USER", "PASS", "ACCT", "CWD", "CDUP", "SMNT", "QUIT", "REIN",
			"PORT", "PASV", "TYPE", "STRU", "MODE", "RETR", "STOR", "STOU", "APPE", "ALLO",
			"REST", "RNFR", "RNTO", "ABOR", "DELE", "RMD", "MKD", "PWD", "LIST", "NLST",
			"SITE", "SYST", "STAT", "HELP", "NOOP", "FEAT", "OPTS", "AUTH", "PBSZ", "PROT",
			"EPRT", "EPSV", "SIZE", "MLSD", "MLST"};
		ftpmon_pkg::out_item_t verdicts[$];
		int errors = 0;
		logic [22:0] flags;
		logic [5:0] last_cmd;
		logic [31:0] msg_count;
		logic [31:0] rest_off;
		int nbytes;
		logic [39:0] tok;
		int toklen;
		logic [31:0] acc;
		int linelen;
		logic [7:0] ph;

		function new();
			flags = '0;
			last_cmd = ftpmon_pkg::V_NONE;
			msg_count = '0;
			rest_off = '0;
			clear_msg();
		endfunction

		function void clear_msg();
			nbytes = 0;
			tok = '0;
			toklen = 0;
			acc = '0;
			linelen = 0;
			ph = '0;
		endfunction

		function bit is_ws(logic [7:0] b);
			return b == 8'h20 || (b >= 8'h09 && b <= 8'h0D);
		endfunction

		function bit is_dig(logic [7:0] b);
			return b >= "0" && b <= "9";
		endfunction

		function void arg_byte(logic [7:0] b);
			logic [63:0] v;
			bit started;
			started = (ph & P_ARGSTART) != 0;
			if (ph & P_ARGSTOP) return;
			if (!started && is_ws(b)) return;
			if (!started && (b == "+" || b == "-")) begin
				ph |= P_ARGSTART;
				if (b == "-") ph |= P_ARGNEG;
				return;
			end
			if (is_dig(b)) begin
				v = 64'(acc) * 10 + 64'(b - "0");
				if (v > 64'h8000_0000) v = 64'h8000_0000;
				acc = v[31:0];
				ph |= P_ARGSTART;
			end else begin
				ph |= P_ARGSTOP;
			end
		endfunction

		function void cmd_byte(logic [7:0] b, bit last);
			logic [7:0] c;
			if (nbytes >= ftpmon_pkg::MAX_COMMAND_LENGTH) ph |= P_BAD;
			if (b == 8'h00 && !last) ph |= P_BAD;
			if (!(ph & P_TOKDONE)) begin
				if (b == 8'h20 || b == 8'h0D || b == 8'h0A || b == 8'h00) begin
					ph |= P_TOKDONE;
					arg_byte(b);
				end else if (toklen < ftpmon_pkg::TOKEN_LIMIT) begin
					c = (b >= "a" && b <= "z") ? b - 8'h20 : b;
					if (toklen < 5) tok[8*toklen +: 8] = c;
					toklen++;
				end else begin
					ph |= P_TOKDONE;
				end
			end else begin
				arg_byte(b);
			end
			if (nbytes < 1023) nbytes++;
		endfunction

		function void close_line();
			int eff;
			eff = linelen;
			if ((ph & P_LASTCR) && eff > 0) eff--;
			if (eff < 4 || (ph & P_LINEFAIL)) ph |= P_BAD;
			linelen = 0;
			ph &= ~(P_LINEFAIL | P_LASTCR);
		endfunction

		function void rpl_byte(logic [7:0] b);
			bit d;
			d = is_dig(b);
			if (nbytes < 3) begin
				if (d) acc = acc * 10 + 32'(b - "0");
				else ph |= P_CODEFAIL;
			end
			if (b == 8'h0A) begin
				close_line();
			end else begin
				if (linelen < 3 && !d) ph |= P_LINEFAIL;
				if (linelen < 1023) linelen++;
				if (b == 8'h0D) ph |= P_LASTCR;
				else ph &= ~P_LASTCR;
			end
			if (nbytes < 1023) nbytes++;
		endfunction

		function logic [5:0] match_verb();
			bit ok;
			if (toklen < 1 || toklen > 4) return ftpmon_pkg::V_NONE;
			for (int k = 0; k < 43; k++) begin
				ok = verbs[k].len() == toklen;
				for (int i = 0; i < toklen && ok; i++)
					if (tok[8*i +: 8] != verbs[k][i]) ok = 0;
				if (ok) return 6'(k + 1);
			end
			return ftpmon_pkg::V_NONE;
		endfunction

		function void push_verdict(bit rep, logic [2:0] cls, logic [9:0] code, bit mal, bit to);
			ftpmon_pkg::out_item_t o;
			o.is_reply = rep;
			o.command_code = last_cmd;
			o.reply_class = cls;
			o.reply_code = code;
			o.sequence_count = msg_count;
			o.restart_position = rest_off;
			o.malformed = mal;
			o.timed_out = to;
			o.session_bits = flags;
			o.auth_phase = flags[ftpmon_pkg::F_LOGGED_IN] ? 3'd4
				: flags[ftpmon_pkg::F_LOGIN_FAIL] ? 3'd3
				: flags[ftpmon_pkg::F_PASS_SENT] ? 3'd2
				: flags[ftpmon_pkg::F_USER_SENT] ? 3'd1 : 3'd0;
			o.data_phase = flags[ftpmon_pkg::F_DATA_OPEN] ? 2'd3
				: flags[ftpmon_pkg::F_PORT_SENT] ? 2'd2
				: flags[ftpmon_pkg::F_PASV_SENT] ? 2'd1 : 2'd0;
			verdicts.push_back(o);
		endfunction

		function void end_command();
			logic [5:0] v;
			bit mal;
			v = match_verb();
			last_cmd = v;
			case (v)
				ftpmon_pkg::V_USER: flags[ftpmon_pkg::F_USER_SENT] = 1;
				ftpmon_pkg::V_PASS: flags[ftpmon_pkg::F_PASS_SENT] = 1;
				ftpmon_pkg::V_PORT: begin
					flags[ftpmon_pkg::F_PORT_SENT] = 1;
					flags[ftpmon_pkg::F_PASV_SENT] = 0;
				end
				ftpmon_pkg::V_PASV: begin
					flags[ftpmon_pkg::F_PASV_SENT] = 1;
					flags[ftpmon_pkg::F_PORT_SENT] = 0;
				end
				ftpmon_pkg::V_RETR: flags[ftpmon_pkg::F_RETR] = 1;
				ftpmon_pkg::V_STOR: flags[ftpmon_pkg::F_STOR] = 1;
				ftpmon_pkg::V_RNFR: flags[ftpmon_pkg::F_RNFR_SENT] = 1;
				ftpmon_pkg::V_RNTO: flags[ftpmon_pkg::F_RNTO] = 1;
				ftpmon_pkg::V_ABOR: begin
					flags[ftpmon_pkg::F_XFER_ABORT] = 1;
					flags[ftpmon_pkg::F_XFER_PROG] = 0;
				end
				ftpmon_pkg::V_QUIT: flags[ftpmon_pkg::F_QUIT] = 1;
				ftpmon_pkg::V_REIN: flags[ftpmon_pkg::F_REIN] = 1;
				ftpmon_pkg::V_REST: begin
					if (ph & P_ARGNEG)
						rest_off = (acc >= 32'h8000_0000) ? 32'h8000_0000 : 32'd0 - acc;
					else
						rest_off = (acc > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : acc;
				end
				default: ;
			endcase
			msg_count++;
			mal = nbytes == 0 || (ph & P_BAD) != 0 || toklen == 0;
			push_verdict(0, 3'd0, 10'd0, mal, 0);
		endfunction

		function void end_reply();
			logic [31:0] code;
			logic [2:0] cls;
			bit mal, first;
			if (linelen > 0) close_line();
			code = (nbytes >= 3 && !(ph & P_CODEFAIL)) ? acc : 32'd0;
			cls = (code >= 100 && code < 600) ? 3'(code / 100) : 3'd0;
			mal = nbytes == 0 || (ph & P_BAD) != 0;
			first = msg_count == 0;
			if (last_cmd == ftpmon_pkg::V_NONE) begin
				if (code == 220 && !first && flags[ftpmon_pkg::F_REIN])
					last_cmd = ftpmon_pkg::V_REIN;
				else if (code == 331 && flags[ftpmon_pkg::F_USER_SENT])
					last_cmd = ftpmon_pkg::V_USER;
				else if (code == 230 && !first && flags[ftpmon_pkg::F_PASS_SENT])
					last_cmd = ftpmon_pkg::V_PASS;
				else if (code == 227 && flags[ftpmon_pkg::F_PASV_SENT])
					last_cmd = ftpmon_pkg::V_PASV;
				else if (code == 350 && flags[ftpmon_pkg::F_RNFR_SENT])
					last_cmd = ftpmon_pkg::V_RNFR;
				else if (code == 221 && flags[ftpmon_pkg::F_QUIT])
					last_cmd = ftpmon_pkg::V_QUIT;
				else if (code == 257) last_cmd = ftpmon_pkg::V_PWD;
				else if (code == 215) last_cmd = ftpmon_pkg::V_SYST;
				else if (code == 211) last_cmd = ftpmon_pkg::V_FEAT;
			end
			if (code == 220 && first) begin
				flags[ftpmon_pkg::F_SESS_INIT] = 1;
			end else if (code == 230) begin
				flags[ftpmon_pkg::F_LOGGED_IN] = 1;
				flags[ftpmon_pkg::F_LOGIN_OK] = 1;
			end else if (code == 530) begin
				flags[ftpmon_pkg::F_LOGIN_FAIL] = 1;
				flags[ftpmon_pkg::F_LOGGED_IN] = 0;
			end else if (code == 200 && last_cmd == ftpmon_pkg::V_PORT) begin
				flags[ftpmon_pkg::F_PORT_ACC] = 1;
			end else if (code == 227) begin
				flags[ftpmon_pkg::F_PASV_RESP] = 1;
			end else if (code == 150) begin
				flags[ftpmon_pkg::F_XFER_START] = 1;
				flags[ftpmon_pkg::F_XFER_PROG] = 1;
				flags[ftpmon_pkg::F_DATA_OPEN] = 1;
			end else if (code == 226) begin
				flags[ftpmon_pkg::F_XFER_DONE] = 1;
				flags[ftpmon_pkg::F_XFER_PROG] = 0;
				flags[ftpmon_pkg::F_DATA_OPEN] = 0;
			end else if (code == 350 && last_cmd == ftpmon_pkg::V_RNFR) begin
				flags[ftpmon_pkg::F_RNFR_ACC] = 1;
			end else if (code == 220 && last_cmd == ftpmon_pkg::V_REIN) begin
				flags = '0;
				flags[ftpmon_pkg::F_SESS_INIT] = 1;
				last_cmd = ftpmon_pkg::V_NONE;
				msg_count = '0;
				rest_off = '0;
			end else if (code == 221) begin
				flags[ftpmon_pkg::F_CLOSED] = 1;
			end
			msg_count++;
			push_verdict(1, cls, code[9:0], mal, code == 0);
		endfunction

		function void note_input(ftpmon_pkg::in_item_t it);
			bit rep;
			if (it.action == ftpmon_pkg::ACT_CMD_EMPTY
					|| it.action == ftpmon_pkg::ACT_RPL_EMPTY) begin
				clear_msg();
				if (it.action == ftpmon_pkg::ACT_RPL_EMPTY) end_reply();
				else end_command();
				return;
			end
			if (nbytes == 0 && it.action == ftpmon_pkg::ACT_RPL_BYTE) ph |= P_DIR;
			rep = (ph & P_DIR) != 0;
			if (rep) rpl_byte(it.byte_value);
			else cmd_byte(it.byte_value, it.last_byte);
			if (!it.last_byte) return;
			if (rep) end_reply();
			else end_command();
			clear_msg();
		endfunction

		task report(string what, logic [31:0] got, logic [31:0] want);
			$display("mismatch %s: got %0h expected %0h", what, got, want);
			errors++;
		endtask

		task check_verdict(ftpmon_pkg::out_item_t got);
			ftpmon_pkg::out_item_t e;
			if (verdicts.size() == 0) begin
				report("unexpected verdict", got.sequence_count, 32'd0);
				return;
			end
			e = verdicts.pop_front();
			if (got.is_reply !== e.is_reply)
				report("is_reply", 32'(got.is_reply), 32'(e.is_reply));
			if (got.command_code !== e.command_code)
				report("command_code", 32'(got.command_code), 32'(e.command_code));
			if (got.reply_class !== e.reply_class)
				report("reply_class", 32'(got.reply_class), 32'(e.reply_class));
			if (got.reply_code !== e.reply_code)
				report("reply_code", 32'(got.reply_code), 32'(e.reply_code));
			if (got.sequence_count !== e.sequence_count)
				report("sequence_count", got.sequence_count, e.sequence_count);
			if (got.restart_position !== e.restart_position)
				report("restart_position", got.restart_position, e.restart_position);
			if (got.malformed !== e.malformed)
				report("malformed", 32'(got.malformed), 32'(e.malformed));
			if (got.timed_out !== e.timed_out)
				report("timed_out", 32'(got.timed_out), 32'(e.timed_out));
			if (got.session_bits !== e.session_bits)
				report("session_bits", 32'(got.session_bits), 32'(e.session_bits));
			if (got.auth_phase !== e.auth_phase)
				report("auth_phase", 32'(got.auth_phase), 32'(e.auth_phase));
			if (got.data_phase !== e.data_phase)
				report("data_phase", 32'(got.data_phase), 32'(e.data_phase));
		endtask
	endclass

	logic clk = 0;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	ftpmon_pkg::in_item_t in_data;
	logic out_valid;
	logic out_ready = 0;
	ftpmon_pkg::out_item_t out_data;

	session_scoreboard sb = new();
	bit quiet = 0;
	int sent = 0;
	int cycles = 0;
	int stall_left = 0;

	ftp_session_state_monitor DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) sb.note_input(in_data);
		if (arst_n && out_valid && out_ready) sb.check_verdict(out_data);
	end

	always @(posedge clk) begin
		if (stall_left > 0) begin
			out_ready <= 0;
			stall_left--;
		end else if (!quiet && $urandom_range(0, 5) == 0) begin
			out_ready <= 0;
			stall_left = $urandom_range(1, 5) - 1;
		end else begin
			out_ready <= 1;
		end
	end

	task send_item(logic [1:0] act, logic [7:0] b, bit last);
		int gap;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 5);
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		in_data <= '{action: act, byte_value: b, last_byte: last};
		do @(posedge clk); while (!in_ready);
		sent++;
	endtask

	task send_text(bit rep, string s);
		if (s.len() == 0) begin
			send_item(rep ? ftpmon_pkg::ACT_RPL_EMPTY : ftpmon_pkg::ACT_CMD_EMPTY,
				8'($urandom), $urandom_range(0, 1));
			return;
		end
		for (int i = 0; i < s.len(); i++)
			send_item(rep ? ftpmon_pkg::ACT_RPL_BYTE : ftpmon_pkg::ACT_CMD_BYTE, s[i],
				i == s.len() - 1);
	endtask

	function string mix_case(string s);
		string r;
		r = s;
		for (int i = 0; i < r.len(); i++)
			if ($urandom_range(0, 1)) begin
				if (r[i] >= "a" && r[i] <= "z") r[i] = r[i] - 8'h20;
				else if (r[i] >= "A" && r[i] <= "Z") r[i] = r[i] + 8'h20;
			end
		return r;
	endfunction

	function string rand_reply();
		int codes[20] = '{220, 230, 530, 227, 150, 226, 350, 221, 257, 215, 211, 331, 200, 125,
			425, 500, 999, 600, 100, 599};
		int c;
		c = codes[$urandom_range(0, 19)];
		case ($urandom_range(0, 3))
			0: return $sformatf("%0d-first\r\n%0d done\r\n", c, c);
			1: return $sformatf("%0d ok\n", c);
			default: return $sformatf("%0d text\r\n", c);
		endcase
	endfunction

	function string rand_command();
		string v, arg;
		int n;
		if ($urandom_range(0, 9) == 0) v = "XQZ";
		else v = sb.verbs[$urandom_range(0, 42)];
		if (v == "REST") begin
			case ($urandom_range(0, 3))
				0: arg = $sformatf(" %0d", $urandom);
				1: arg = $sformatf("  -%0d%0d", $urandom, $urandom_range(0, 99));
				2: arg = $sformatf(" +%0dx9", $urandom_range(0, 9999));
				default: arg = "";
			endcase
		end else begin
			arg = "";
			n = $urandom_range(0, 6);
			if (n > 0) arg = " ";
			for (int i = 0; i < n; i++)
				arg = {arg, $sformatf("%c", 8'($urandom_range(33, 126)))};
		end
		return {mix_case(v), arg, "\r\n"};
	endfunction

	task send_noise(int n, bit dir_mix);
		logic [1:0] act;
		for (int i = 0; i < n; i++) begin
			act = dir_mix ? 2'($urandom_range(0, 1)) : ftpmon_pkg::ACT_CMD_BYTE;
			send_item(act, 8'($urandom), i == n - 1);
		end
	endtask

	initial begin
		arst_n = 0;
		in_valid = 0;
		in_data = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		send_text(1, "220 ready\r\n");
		send_text(0, "user anon\r\n");
		send_text(1, "331 need pass\r\n");
		send_text(0, "PaSs x\r\n");
		send_text(1, "230 in\r\n");
		send_text(0, "PASV\r\n");
		send_text(1, "227 p\r\n");
		send_text(0, "PORT 1,2\r\n");
		send_text(1, "200 ok\r\n");
		send_text(0, "RETR f\r\n");
		send_text(1, "150 open\r\n");
		send_text(1, "226 done\r\n");
		send_text(0, "REST -2147483649\r\n");
		send_text(0, "REST +99999999999\r\n");
		send_text(0, "REST \t 12a7\r\n");
		send_text(0, "RNFR a\r\n");
		send_text(1, "350 x\r\n");
		send_text(0, "ABOR\r\n");
		send_text(1, "530 no\r\n");
		send_text(0, "");
		send_text(1, "");
		send_text(0, "ABCDEFGHIJKLMNOPQR x\r\n");
		send_item(ftpmon_pkg::ACT_CMD_BYTE, "N", 0);
		send_item(ftpmon_pkg::ACT_CMD_BYTE, 8'h00, 0);
		send_item(ftpmon_pkg::ACT_CMD_BYTE, "P", 0);
		send_item(ftpmon_pkg::ACT_CMD_BYTE, 8'h00, 1);
		send_text(1, "2a0 x\r\n12\r\n");
		send_item(ftpmon_pkg::ACT_RPL_BYTE, "5", 0);
		send_item(ftpmon_pkg::ACT_CMD_EMPTY, 8'hFF, 1);
		send_text(0, "QUIT\r\n");
		send_text(1, "221 bye\r\n");
		send_text(0, "REIN\r\n");
		send_text(0, "XYZ\r\n");
		send_text(1, "220 again\r\n");
		send_text(0, "REIN\r\n");
		send_text(1, "220 again\r\n");

		while (sent < ITEM_TARGET) begin
			if (sent > QUIET_FROM) quiet = 1;
			case ($urandom_range(0, 9))
				0, 1, 2, 3: begin
					send_text(0, rand_command());
					if ($urandom_range(0, 3) != 0) send_text(1, rand_reply());
				end
				4, 5: send_text(1, rand_reply());
				6: send_noise($urandom_range(1, 8), 1);
				7: send_noise($urandom_range(1, 4), 1);
				8: send_text(1, $urandom_range(0, 1) ? "2x\n" : "123\r\n45\n");
				default: send_noise($urandom_range(1, 6), 0);
			endcase
		end
		in_valid <= 0;

		while (sb.verdicts.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (sb.errors == 0 && sb.verdicts.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end
endmodule

FILE: ftp_session_state_monitor.f
+incdir+rtl
rtl/ftpmon_pkg.sv
rtl/ftp_session_state_monitor.sv
dv/ftp_session_state_monitor_tb.sv
